>>> rtl/sbus_frame_decoder_macros.svh
// ----------------------------------------------------------------------------
// sbus_frame_decoder_macros.svh
// Assertion shorthands for the frame decoder.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define SBUS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbus_frame_decoder: assertion failed");

// Next-cycle implication.
`define SBUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbus_frame_decoder: assertion failed");

`endif

>>> rtl/sbus_pkg.sv
// ----------------------------------------------------------------------------
// sbus_pkg
// Shared constants and types of the 16-channel frame decoder.
// ----------------------------------------------------------------------------
package sbus_pkg;

	localparam int CHANNELS  = 16;
	localparam int CH_W      = $clog2(CHANNELS);
	localparam int RAW_W     = 11;
	localparam int BAND_W    = 8;
	localparam int NORM_W    = 16;
	localparam int FRAC_BITS = 14;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int STEP_W    = 4;
	localparam int ACC_W     = 18;
	localparam int HELD_W    = 5;
	localparam int POS_W     = 5;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [7:0]        HEADER_BYTE = 8'h0F;
	localparam logic [POS_W-1:0]  POS_IDLE    = 5'd31;
	localparam logic [POS_W-1:0]  POS_FLAGS   = 5'd23;
	localparam logic [POS_W-1:0]  POS_FOOTER  = 5'd24;
	localparam logic [QUO_W-1:0]  Q_ONE       = 15'd16384;

	localparam logic [RAW_W-1:0]  MAX_RST     = 11'd1680;
	localparam logic [RAW_W-1:0]  NEUTRAL_RST = 11'd1024;
	localparam logic [RAW_W-1:0]  MIN_RST     = 11'd368;
	localparam logic [BAND_W-1:0] BAND_RST    = 8'd20;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_MAX     = 2'd0;
	localparam logic [1:0] REG_NEUTRAL = 2'd1;
	localparam logic [1:0] REG_MIN     = 2'd2;
	localparam logic [1:0] REG_BAND    = 2'd3;

	localparam logic [1:0] LINK_OK       = 2'd0;
	localparam logic [1:0] LINK_LOST     = 2'd1;
	localparam logic [1:0] LINK_FAILSAFE = 2'd2;

	typedef struct packed {
		logic             start;
		logic [RAW_W-1:0] dividend;
		logic [RAW_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/sbus_in_if.sv
// ----------------------------------------------------------------------------
// sbus_in_if
// Byte channel into the decoder: one received byte per transaction.
// ----------------------------------------------------------------------------
interface sbus_in_if import sbus_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_start;

	modport source (output valid, output frame_byte, output frame_start, input ready);
	modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

>>> rtl/sbus_out_if.sv
// ----------------------------------------------------------------------------
// sbus_out_if
// Result channel: one decoded channel per transaction.
// ----------------------------------------------------------------------------
interface sbus_out_if import sbus_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CH_W-1:0]          channel_index;
	logic [RAW_W-1:0]         raw_value;
	logic signed [NORM_W-1:0] normalized;
	logic                     digital_one;
	logic                     digital_two;
	logic [1:0]               link_status;
	logic                     last;

	modport source (output valid, output channel_index, output raw_value, output normalized,
		output digital_one, output digital_two, output link_status, output last,
		input ready);
	modport sink (input valid, input channel_index, input raw_value, input normalized,
		input digital_one, input digital_two, input link_status, input last,
		output ready);
endinterface

>>> rtl/sbus_qdiv.sv
// ----------------------------------------------------------------------------
// sbus_qdiv
// Restoring divider, one compare/subtract per cycle: dividend * 2^14 / divisor
// saturated to 2^14. Zero divisor saturates.
// ----------------------------------------------------------------------------
module sbus_qdiv import sbus_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RAW_W:0]    rem_q;
	logic [RAW_W-1:0]  div_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic              sat_q;

	logic [RAW_W:0] cand;
	logic [RAW_W:0] diff;
	logic           ge;

	// step 0 checks the integer bit, later steps shift the remainder first
	assign cand = (step_q == '0) ? rem_q : {rem_q[RAW_W-1:0], 1'b0};
	assign ge   = cand >= {1'b0, div_q};
	assign diff = cand - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == '0) begin
					if (ge) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						step_q <= 4'd1;
					end
				end else if (step_q == STEP_W'(FRAC_BITS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {1'b0, req.dividend};
			div_q <= req.divisor;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			if (step_q == '0) begin
				sat_q <= ge;
			end else begin
				rem_q <= ge ? diff : cand;
				quo_q <= {quo_q[FRAC_BITS-2:0], ge};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = sat_q ? Q_ONE : {1'b0, quo_q};

endmodule

>>> rtl/sbus_frame_decoder.sv
// A header, data or footer byte is taken while idle; input stays ready for the next byte.
// The flags byte of a valid frame starts 16 results, each made by a store read, setup,
// a pass through the shared divider (skipped inside the dead band) and output, which
// waits for a ready sink; no byte is taken until the last result is accepted.
// Reset (arst_n low, asynchronous): registers to calibration defaults, no frame open.
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Unpacks 16 x 11-bit channels from a 25-byte serial RC frame and emits one
// normalized result per channel when the flags byte of a frame with a 0x0F header arrives.
// ----------------------------------------------------------------------------
`include "sbus_frame_decoder_macros.svh"

module sbus_frame_decoder import sbus_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sbus_in_if.sink           frame,
	sbus_out_if.source        result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_SETUP = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	// ---------------- configuration registers ----------------
	logic [RAW_W-1:0]  stick_max_q;
	logic [RAW_W-1:0]  stick_neutral_q;
	logic [RAW_W-1:0]  stick_min_q;
	logic [BAND_W-1:0] dead_band_q;
	logic              cfg_wr;
	logic [1:0]        cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_max_q     <= MAX_RST;
			stick_neutral_q <= NEUTRAL_RST;
			stick_min_q     <= MIN_RST;
			dead_band_q     <= BAND_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MAX:     stick_max_q     <= pwdata[RAW_W-1:0];
				REG_NEUTRAL: stick_neutral_q <= pwdata[RAW_W-1:0];
				REG_MIN:     stick_min_q     <= pwdata[RAW_W-1:0];
				REG_BAND:    dead_band_q     <= pwdata[BAND_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_MAX:     prdata = DATA_W'(stick_max_q);
			REG_NEUTRAL: prdata = DATA_W'(stick_neutral_q);
			REG_MIN:     prdata = DATA_W'(stick_min_q);
			REG_BAND:    prdata = DATA_W'(dead_band_q);
			default:     prdata = '0;
		endcase
	end

	// ---------------- frame tracking and bit unpacking ----------------
	state_t            state_q;
	logic [POS_W-1:0]  pos_q;        // byte position in the frame, POS_IDLE when closed
	logic              hdr_ok_q;     // header of the open frame was 0x0F
	logic [ACC_W-1:0]  acc_q;        // unconsumed bits, LSB first
	logic [HELD_W-1:0] held_q;       // number of valid bits in acc_q
	logic [CH_W:0]     filled_q;     // channels written so far
	logic [CH_W-1:0]   k_q;          // channel being emitted
	logic [7:0]        flags_q;

	logic              in_acc;
	logic [ACC_W-1:0]  acc_ext;
	logic [HELD_W-1:0] held_sum;
	logic              take_ch;
	logic              data_byte;

	assign frame.ready = (state_q == ST_IDLE);
	assign in_acc      = frame.valid && frame.ready;

	// held_q never exceeds 10, so the shifted byte always fits in 18 bits
	assign acc_ext   = acc_q | (ACC_W'(frame.frame_byte) << held_q);
	assign held_sum  = held_q + HELD_W'(8);
	assign data_byte = in_acc && !frame.frame_start && (pos_q < POS_FLAGS);
	// at most one channel completes per byte (10 + 8 - 11 < 11)
	assign take_ch   = hdr_ok_q && (held_sum >= HELD_W'(RAW_W))
		&& (filled_q < (CH_W + 1)'(CHANNELS));

	// channel store: one write port (unpacking), one registered read port (emission)
	logic [RAW_W-1:0] store_mem [CHANNELS];
	logic [RAW_W-1:0] raw_q;

	always_ff @(posedge clk) begin
		if (data_byte && take_ch) begin
			store_mem[filled_q[CH_W-1:0]] <= acc_ext[RAW_W-1:0];
		end
		if (state_q == ST_READ) begin
			raw_q <= store_mem[k_q];
		end
	end

	// ---------------- normalization setup ----------------
	// Both sides reduce to |num| / |den| with the result negative exactly when
	// the selected divisor is negative; a zero divisor saturates positive.
	logic [RAW_W:0]   r12, n12, b12;
	logic             above, below;
	logic [RAW_W:0]   den_hi, den_lo, den_sel;
	logic             den_neg;
	logic [RAW_W:0]   num_hi, num_lo;
	logic [RAW_W:0]   den_abs;
	logic             den_neg_q;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	assign r12     = {1'b0, raw_q};
	assign n12     = {1'b0, stick_neutral_q};
	assign b12     = (RAW_W + 1)'(dead_band_q);
	assign above   = r12 > (n12 + b12);
	assign below   = (r12 + b12) < n12;
	assign den_hi  = {1'b0, stick_max_q} - n12;
	assign den_lo  = {1'b0, stick_min_q} - n12;
	assign den_sel = above ? den_hi : den_lo;
	assign den_neg = den_sel[RAW_W];
	assign den_abs = den_neg ? (~den_sel + 1'b1) : den_sel;
	assign num_hi  = r12 - n12;
	assign num_lo  = n12 - r12;

	assign div_req.start    = (state_q == ST_SETUP) && (above || below);
	assign div_req.dividend = above ? num_hi[RAW_W-1:0] : num_lo[RAW_W-1:0];
	assign div_req.divisor  = den_abs[RAW_W-1:0];

	sbus_qdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	logic [NORM_W-1:0] q_ext;
	assign q_ext = NORM_W'(div_rsp.quotient);

	// ---------------- output register ----------------
	logic                     out_valid_q;
	logic [CH_W-1:0]          out_idx_q;
	logic [RAW_W-1:0]         out_raw_q;
	logic signed [NORM_W-1:0] out_norm_q;
	logic                     out_d1_q;
	logic                     out_d2_q;
	logic [1:0]               out_link_q;
	logic                     out_last_q;

	assign result.valid         = out_valid_q;
	assign result.channel_index = out_idx_q;
	assign result.raw_value     = out_raw_q;
	assign result.normalized    = out_norm_q;
	assign result.digital_one   = out_d1_q;
	assign result.digital_two   = out_d2_q;
	assign result.link_status   = out_link_q;
	assign result.last          = out_last_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= POS_IDLE;
			hdr_ok_q    <= 1'b0;
			acc_q       <= '0;
			held_q      <= '0;
			filled_q    <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						priority if (frame.frame_start) begin
							// new frame, drops any open one
							hdr_ok_q <= (frame.frame_byte == HEADER_BYTE);
							acc_q    <= '0;
							held_q   <= '0;
							filled_q <= '0;
							pos_q    <= 5'd1;
						end else if (pos_q == POS_IDLE) begin
							// stray byte outside a frame
						end else if (pos_q < POS_FLAGS) begin
							if (hdr_ok_q) begin
								if (take_ch) begin
									acc_q    <= acc_ext >> RAW_W;
									held_q   <= held_sum - HELD_W'(RAW_W);
									filled_q <= filled_q + 1'b1;
								end else begin
									acc_q  <= acc_ext;
									held_q <= held_sum;
								end
							end
							pos_q <= pos_q + 1'b1;
						end else if (pos_q == POS_FLAGS) begin
							pos_q <= POS_FOOTER;
							if (hdr_ok_q) begin
								k_q     <= '0;
								state_q <= ST_READ;
							end
						end else begin
							// footer closes the frame
							pos_q <= POS_IDLE;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					if (above || below) begin
						state_q <= ST_DIV;
					end else begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (result.ready) begin
						out_valid_q <= 1'b0;
						if (k_q == CH_W'(CHANNELS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_acc && !frame.frame_start && (pos_q == POS_FLAGS)) begin
			flags_q <= frame.frame_byte;
		end
		if (state_q == ST_SETUP) begin
			den_neg_q  <= den_neg;
			out_idx_q  <= k_q;
			out_raw_q  <= raw_q;
			out_norm_q <= '0;
			out_d1_q   <= flags_q[0];
			out_d2_q   <= flags_q[1];
			out_last_q <= (k_q == CH_W'(CHANNELS - 1));
			priority if (flags_q[3]) begin
				out_link_q <= LINK_FAILSAFE;
			end else if (flags_q[2]) begin
				out_link_q <= LINK_LOST;
			end else begin
				out_link_q <= LINK_OK;
			end
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			out_norm_q <= den_neg_q ? (~q_ext + 1'b1) : q_ext;
		end
	end

	// ---------------- assertions ----------------
	`SBUS_ASSERT_IMPL(a_no_input_while_emitting, clk, arst_n, frame.ready, !result.valid)
	`SBUS_ASSERT_NEXT(a_ready_after_last, clk, arst_n,
		result.valid && result.ready && result.last, frame.ready)
	`SBUS_ASSERT_IMPL(a_div_done_in_div, clk, arst_n, div_rsp.done, state_q == ST_DIV)
	`SBUS_ASSERT_IMPL(a_filled_bound, clk, arst_n, 1'b1,
		filled_q <= (CH_W + 1)'(CHANNELS))

endmodule
